/* rtl/sorf_pkg.sv */
// ----------------------------------------------------------------------------
// Sequenced overwrite ring feed: shared types and codes
// Operation codes, reason codes, flag positions and the request record that
// travels from the front end through the queue to the back end.
// ----------------------------------------------------------------------------
package sorf_pkg;

    localparam int WORD_W   = 64;
    localparam int LIMIT_W  = 8;
    localparam int FLAG_W   = 4;
    localparam int REASON_W = 3;

    typedef logic [1:0]          t_op;
    typedef logic [WORD_W-1:0]   t_word;
    typedef logic [LIMIT_W-1:0]  t_limit;
    typedef logic [FLAG_W-1:0]   t_flags;
    typedef logic [REASON_W-1:0] t_reason;

    // Operation codes
    localparam t_op OP_PUBLISH = 2'd0;
    localparam t_op OP_READ    = 2'd1;
    localparam t_op OP_RESTART = 2'd2;
    localparam t_op OP_NONE    = 2'd3;

    // Reason codes of a read
    localparam t_reason REASON_RESTART_GAP = 3'd0;
    localparam t_reason REASON_RESTART     = 3'd1;
    localparam t_reason REASON_GAP         = 3'd2;
    localparam t_reason REASON_AHEAD       = 3'd3;
    localparam t_reason REASON_CAPPED      = 3'd4;
    localparam t_reason REASON_NOTHING     = 3'd5;
    localparam t_reason REASON_DELIVERED   = 3'd6;

    // Flag bit positions
    localparam int FLAG_EPOCH = 0;
    localparam int FLAG_GAP   = 1;
    localparam int FLAG_AHEAD = 2;
    localparam int FLAG_MORE  = 3;

    // Request queue between front and back end
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        t_op    op;
        t_word  payload;
        t_word  cursor;
        t_word  cursor_epoch;
        t_limit limit;
    } t_cmd;

endpackage

/* rtl/sequenced_overwrite_ring_feed_unit.sv */
// A publish or restart passes S_PUB or S_RST and then S_SINGLE, where its result
// is loaded into the output register; a read steps through S_R1 to S_R7 and
// S_ADDR before its records. The back end finishes one request before it takes
// the next, and delivers one record per cycle from the ring RAM unless stalled.
// A two-entry request queue lets new requests in while the back end works.
// Reset (synchronous, active low): empty ring, sequence 0, epoch 1, no output.
// ----------------------------------------------------------------------------
// Sequenced overwrite ring feed
// Overwriting ring of records with sequence numbers, epoch tracking and
// batched cursor reads with gap and restart detection.
// ----------------------------------------------------------------------------
module sequenced_overwrite_ring_feed_unit #(
    parameter int RING_DEPTH   = 16,
    parameter int BATCH_MAX    = 16,
    parameter int RECORD_WIDTH = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  sorf_pkg::t_op     i_operation,
    input  sorf_pkg::t_word   i_payload,
    input  sorf_pkg::t_word   i_cursor,
    input  sorf_pkg::t_word   i_cursor_epoch,
    input  sorf_pkg::t_limit  i_batch_limit,
    output logic              o_valid,
    input  logic              i_stall,
    output logic              o_has_record,
    output sorf_pkg::t_word   o_record_word,
    output sorf_pkg::t_word   o_seq_number,
    output logic              o_final_item,
    output sorf_pkg::t_word   o_lost_count,
    output sorf_pkg::t_word   o_feed_epoch,
    output sorf_pkg::t_word   o_newest_seq,
    output sorf_pkg::t_word   o_oldest_seq,
    output sorf_pkg::t_word   o_resume_cursor,
    output sorf_pkg::t_flags  o_flag_bits,
    output sorf_pkg::t_reason o_reason_code
);
    import sorf_pkg::*;

    logic w_push;
    t_cmd w_push_cmd;
    logic w_q_full;
    logic w_q_valid;
    t_cmd w_q_cmd;
    logic w_q_pop;

    // Decode and clamp incoming requests
    sorf_front #(
        .BATCH_MAX (BATCH_MAX)
    ) u_front (
        .i_valid        (i_valid),
        .i_operation    (i_operation),
        .i_payload      (i_payload),
        .i_cursor       (i_cursor),
        .i_cursor_epoch (i_cursor_epoch),
        .i_batch_limit  (i_batch_limit),
        .i_q_full       (w_q_full),
        .o_stall        (o_stall),
        .o_push         (w_push),
        .o_cmd          (w_push_cmd)
    );

    // Buffer requests between front and back
    sorf_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_push),
        .i_push_cmd (w_push_cmd),
        .o_full     (w_q_full),
        .o_valid    (w_q_valid),
        .o_cmd      (w_q_cmd),
        .i_pop      (w_q_pop)
    );

    // Execute requests against the ring
    sorf_back #(
        .RING_DEPTH   (RING_DEPTH),
        .BATCH_MAX    (BATCH_MAX),
        .RECORD_WIDTH (RECORD_WIDTH)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_valid       (w_q_valid),
        .i_q_cmd         (w_q_cmd),
        .o_q_pop         (w_q_pop),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_has_record    (o_has_record),
        .o_record_word   (o_record_word),
        .o_seq_number    (o_seq_number),
        .o_final_item    (o_final_item),
        .o_lost_count    (o_lost_count),
        .o_feed_epoch    (o_feed_epoch),
        .o_newest_seq    (o_newest_seq),
        .o_oldest_seq    (o_oldest_seq),
        .o_resume_cursor (o_resume_cursor),
        .o_flag_bits     (o_flag_bits),
        .o_reason_code   (o_reason_code)
    );

endmodule

/* rtl/sorf_ram.sv */
// ----------------------------------------------------------------------------
// Generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module sorf_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* rtl/sorf_front.sv */
// ----------------------------------------------------------------------------
// Ring feed front end
// Accepts requests, drops unknown operations and clamps the batch limit
// before the request enters the queue.
// ----------------------------------------------------------------------------
module sorf_front #(
    parameter int BATCH_MAX = 16
) (
    input  logic             i_valid,
    input  sorf_pkg::t_op    i_operation,
    input  sorf_pkg::t_word  i_payload,
    input  sorf_pkg::t_word  i_cursor,
    input  sorf_pkg::t_word  i_cursor_epoch,
    input  sorf_pkg::t_limit i_batch_limit,
    input  logic             i_q_full,
    output logic             o_stall,
    output logic             o_push,
    output sorf_pkg::t_cmd   o_cmd
);
    import sorf_pkg::*;

    t_limit w_limit_lo;

    // Hold the request while the queue is full
    assign o_stall = i_q_full;

    // Drop unknown operations: accepted but never queued
    assign o_push = i_valid && !i_q_full && (i_operation != OP_NONE);

    // Raise a zero limit to one, clamp to the batch maximum
    assign w_limit_lo = (i_batch_limit == '0) ? LIMIT_W'(1) : i_batch_limit;

    always_comb begin
        o_cmd.op           = i_operation;
        o_cmd.payload      = i_payload;
        o_cmd.cursor       = i_cursor;
        o_cmd.cursor_epoch = i_cursor_epoch;
        o_cmd.limit        = (w_limit_lo > LIMIT_W'(BATCH_MAX)) ?
                             LIMIT_W'(BATCH_MAX) : w_limit_lo;
    end

endmodule

/* rtl/sorf_queue.sv */
// ----------------------------------------------------------------------------
// Ring feed request queue
// Short FIFO that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module sorf_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  sorf_pkg::t_cmd i_push_cmd,
    output logic           o_full,
    output logic           o_valid,
    output sorf_pkg::t_cmd o_cmd,
    input  logic           i_pop
);
    import sorf_pkg::*;

    t_cmd                r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr;
    logic [QUEUE_AW-1:0] r_rd;
    logic [QUEUE_AW:0]   r_cnt;
    logic [QUEUE_AW:0]   n_cnt;

    assign o_full  = (r_cnt == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_mem[r_rd];

    // Track fill level
    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + (QUEUE_AW+1)'(1);
        end else if (i_pop && !i_push) begin
            n_cnt = r_cnt - (QUEUE_AW+1)'(1);
        end
    end

    // Advance pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (i_push) begin
                r_wr <= r_wr + QUEUE_AW'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + QUEUE_AW'(1);
            end
        end
    end

    // Store request
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_push_cmd;
        end
    end

endmodule

/* rtl/sorf_back.sv */
// ----------------------------------------------------------------------------
// Ring feed back end
// Holds the ring, sequence and epoch state, executes publish, restart and
// read requests, and streams results through an output register.
// ----------------------------------------------------------------------------
module sorf_back #(
    parameter int RING_DEPTH   = 16,
    parameter int BATCH_MAX    = 16,
    parameter int RECORD_WIDTH = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_valid,
    input  sorf_pkg::t_cmd    i_q_cmd,
    output logic              o_q_pop,
    output logic              o_valid,
    input  logic              i_stall,
    output logic              o_has_record,
    output sorf_pkg::t_word   o_record_word,
    output sorf_pkg::t_word   o_seq_number,
    output logic              o_final_item,
    output sorf_pkg::t_word   o_lost_count,
    output sorf_pkg::t_word   o_feed_epoch,
    output sorf_pkg::t_word   o_newest_seq,
    output sorf_pkg::t_word   o_oldest_seq,
    output sorf_pkg::t_word   o_resume_cursor,
    output sorf_pkg::t_flags  o_flag_bits,
    output sorf_pkg::t_reason o_reason_code
);
    import sorf_pkg::*;

    localparam int IW  = $clog2(RING_DEPTH);
    localparam int IW1 = IW + 1;
    localparam int HW  = $clog2(RING_DEPTH + 1);
    localparam int CW  = $clog2(BATCH_MAX + 1);

    // Sequencer states
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_PUB    = 4'd1;
    localparam logic [3:0] S_RST    = 4'd2;
    localparam logic [3:0] S_R1     = 4'd3;
    localparam logic [3:0] S_R2     = 4'd4;
    localparam logic [3:0] S_R3     = 4'd5;
    localparam logic [3:0] S_R4     = 4'd6;
    localparam logic [3:0] S_R5     = 4'd7;
    localparam logic [3:0] S_R6     = 4'd8;
    localparam logic [3:0] S_R7     = 4'd9;
    localparam logic [3:0] S_ADDR   = 4'd10;
    localparam logic [3:0] S_DATA   = 4'd11;
    localparam logic [3:0] S_SINGLE = 4'd12;

    // Feed state
    logic [3:0]  r_state;
    logic [3:0]  n_state;
    t_word       r_last;
    logic [HW-1:0] r_held;
    t_word       r_oldest;
    t_word       r_epoch;
    t_word       n_epoch;
    t_word       w_epoch_inc;
    logic [IW-1:0] r_wr_ptr;
    logic [IW-1:0] w_wr_next;

    // Request being worked on
    t_cmd        r_cmd;
    t_word       r_eff;
    t_word       r_first;
    t_word       r_lost;
    t_word       r_diff;
    logic        r_le;
    logic        r_f_epoch;
    logic        r_f_ahead;
    logic        r_f_gap;
    logic        r_more;
    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic [CW-1:0] r_left;
    logic [IW-1:0] r_idx;
    logic [IW-1:0] w_idx_next;
    logic [IW1-1:0] w_off;
    logic [IW1-1:0] w_wr_ext;
    logic [IW-1:0] w_start_idx;
    t_word       r_seq;
    t_word       r_res_seq;
    t_word       r_resume;
    t_flags      r_flags;
    t_reason     r_reason;
    t_reason     n_reason;
    logic        w_ep_mismatch;
    logic        w_gap;
    logic        w_cap;

    // Output register
    logic        r_out_valid;
    logic        n_out_valid;
    logic        r_out_has;
    t_word       r_out_word;
    t_word       r_out_seq;
    logic        r_out_final;
    t_word       r_out_lost;
    t_word       r_out_epoch;
    t_word       r_out_newest;
    t_word       r_out_oldest;
    t_word       r_out_resume;
    t_flags      r_out_flags;
    t_reason     r_out_reason;

    // Ring memory
    logic                    w_rd_en;
    logic [IW-1:0]           w_rd_addr;
    logic [RECORD_WIDTH-1:0] w_rd_data;

    logic w_out_free;
    logic w_ld_single;
    logic w_ld_rec;

    sorf_ram #(
        .WIDTH (RECORD_WIDTH),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .i_clk     (i_clk),
        .i_wr_en   (r_state == S_PUB),
        .i_wr_addr (r_wr_ptr),
        .i_wr_data (r_cmd.payload[RECORD_WIDTH-1:0]),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    // Handshake and load conditions
    assign w_out_free  = !r_out_valid || !i_stall;
    assign w_ld_single = (r_state == S_SINGLE) && w_out_free;
    assign w_ld_rec    = (r_state == S_DATA) && w_out_free;
    assign o_q_pop     = (r_state == S_IDLE) && i_q_valid;

    // Ring pointer arithmetic
    assign w_wr_next  = (r_wr_ptr == IW'(RING_DEPTH - 1)) ? '0 : r_wr_ptr + IW'(1);
    assign w_idx_next = (r_idx == IW'(RING_DEPTH - 1)) ? '0 : r_idx + IW'(1);
    assign w_wr_ext   = {1'b0, r_wr_ptr};
    assign w_off      = {1'b0, r_diff[IW-1:0]} + IW1'(1);
    assign w_start_idx = (w_wr_ext >= w_off) ? IW'(w_wr_ext - w_off)
                                             : IW'(w_wr_ext + IW1'(RING_DEPTH) - w_off);

    // Read port: first address, then the next one on each delivered record
    assign w_rd_en   = (r_state == S_ADDR) || w_ld_rec;
    assign w_rd_addr = (r_state == S_ADDR) ? r_idx : w_idx_next;

    // Epoch advance skips zero
    assign w_epoch_inc = r_epoch + 64'd1;
    assign n_epoch     = (w_epoch_inc == '0) ? 64'd1 : w_epoch_inc;

    // Read classification terms
    assign w_ep_mismatch = (r_cmd.cursor_epoch != '0) && (r_cmd.cursor_epoch != r_epoch);
    assign w_gap         = (r_held != '0) && (r_first < r_oldest);
    assign w_cap         = (r_diff >= 64'(r_cmd.limit));

    always_comb begin
        if (!r_le) begin
            n_count = '0;
        end else if (w_cap) begin
            n_count = CW'(r_cmd.limit);
        end else begin
            n_count = r_diff[CW-1:0] + CW'(1);
        end
    end

    // Reason in priority order
    always_comb begin
        priority if (r_f_epoch && r_f_gap) begin
            n_reason = REASON_RESTART_GAP;
        end else if (r_f_epoch) begin
            n_reason = REASON_RESTART;
        end else if (r_f_gap) begin
            n_reason = REASON_GAP;
        end else if (r_f_ahead) begin
            n_reason = REASON_AHEAD;
        end else if (r_more) begin
            n_reason = REASON_CAPPED;
        end else if (r_count == '0) begin
            n_reason = REASON_NOTHING;
        end else begin
            n_reason = REASON_DELIVERED;
        end
    end

    // Sequence the request
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    case (i_q_cmd.op)
                        OP_PUBLISH: n_state = S_PUB;
                        OP_RESTART: n_state = S_RST;
                        OP_READ:    n_state = S_R1;
                        default:    n_state = S_IDLE;
                    endcase
                end
            end
            S_PUB:    n_state = S_SINGLE;
            S_RST:    n_state = S_SINGLE;
            S_R1:     n_state = S_R2;
            S_R2:     n_state = S_R3;
            S_R3:     n_state = S_R4;
            S_R4:     n_state = S_R5;
            S_R5:     n_state = S_R6;
            S_R6:     n_state = S_R7;
            S_R7:     n_state = (r_count == '0) ? S_SINGLE : S_ADDR;
            S_ADDR:   n_state = S_DATA;
            S_DATA: begin
                if (w_ld_rec && (r_left == CW'(1))) begin
                    n_state = S_IDLE;
                end
            end
            S_SINGLE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default:  n_state = S_IDLE;
        endcase
    end

    // Output valid: set on load, drop when taken
    always_comb begin
        n_out_valid = r_out_valid;
        if (w_ld_single || w_ld_rec) begin
            n_out_valid = 1'b1;
        end else if (!i_stall) begin
            n_out_valid = 1'b0;
        end
    end

    // Control and feed state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_last      <= '0;
            r_held      <= '0;
            r_oldest    <= '0;
            r_epoch     <= 64'd1;
            r_wr_ptr    <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (r_state == S_PUB) begin
                r_last   <= r_last + 64'd1;
                r_wr_ptr <= w_wr_next;
                if (r_held == '0) begin
                    r_oldest <= r_last + 64'd1;
                end else if (r_held == HW'(RING_DEPTH)) begin
                    r_oldest <= r_oldest + 64'd1;
                end
                if (r_held < HW'(RING_DEPTH)) begin
                    r_held <= r_held + HW'(1);
                end
            end else if (r_state == S_RST) begin
                r_last   <= '0;
                r_held   <= '0;
                r_oldest <= '0;
                r_wr_ptr <= '0;
                r_epoch  <= n_epoch;
            end
        end
    end

    // Request working registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    r_cmd <= i_q_cmd;
                end
            end
            S_PUB, S_RST: begin
                r_res_seq <= (r_state == S_PUB) ? r_last + 64'd1 : '0;
                r_lost    <= '0;
                r_resume  <= '0;
                r_flags   <= '0;
                r_reason  <= REASON_RESTART_GAP;
            end
            // Restarted feed resets the cursor
            S_R1: begin
                r_f_epoch <= w_ep_mismatch;
                r_eff     <= w_ep_mismatch ? '0 : r_cmd.cursor;
            end
            // Cursor ahead of the feed pulls back to newest
            S_R2: begin
                r_f_ahead <= (r_eff > r_last);
                if (r_eff > r_last) begin
                    r_eff <= r_last;
                end
            end
            S_R3: begin
                r_first <= r_eff + 64'd1;
            end
            // Gap: skip to the oldest held record
            S_R4: begin
                r_f_gap <= w_gap;
                r_lost  <= w_gap ? r_oldest - r_first : '0;
                if (w_gap) begin
                    r_first <= r_oldest;
                end
            end
            S_R5: begin
                r_diff <= r_last - r_first;
                r_le   <= (r_first <= r_last);
            end
            S_R6: begin
                r_count <= n_count;
                r_more  <= r_le && w_cap;
                r_idx   <= w_start_idx;
            end
            S_R7: begin
                r_resume  <= (r_count != '0) ? r_first + 64'(r_count - CW'(1)) : r_eff;
                r_flags   <= {r_more, r_f_ahead, r_f_gap, r_f_epoch};
                r_reason  <= n_reason;
                r_seq     <= r_first;
                r_left    <= r_count;
                r_res_seq <= '0;
            end
            // Advance through the batch
            S_DATA: begin
                if (w_ld_rec) begin
                    r_seq  <= r_seq + 64'd1;
                    r_left <= r_left - CW'(1);
                    r_idx  <= w_idx_next;
                end
            end
            default: ;
        endcase
    end

    // Load the output register
    always_ff @(posedge i_clk) begin
        if (w_ld_single || w_ld_rec) begin
            r_out_has    <= w_ld_rec;
            r_out_word   <= w_ld_rec ? 64'(w_rd_data) : '0;
            r_out_seq    <= w_ld_rec ? r_seq : r_res_seq;
            r_out_final  <= w_ld_single || (r_left == CW'(1));
            r_out_lost   <= r_lost;
            r_out_epoch  <= r_epoch;
            r_out_newest <= r_last;
            r_out_oldest <= r_oldest;
            r_out_resume <= r_resume;
            r_out_flags  <= r_flags;
            r_out_reason <= r_reason;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_has_record    = r_out_has;
    assign o_record_word   = r_out_word;
    assign o_seq_number    = r_out_seq;
    assign o_final_item    = r_out_final;
    assign o_lost_count    = r_out_lost;
    assign o_feed_epoch    = r_out_epoch;
    assign o_newest_seq    = r_out_newest;
    assign o_oldest_seq    = r_out_oldest;
    assign o_resume_cursor = r_out_resume;
    assign o_flag_bits     = r_out_flags;
    assign o_reason_code   = r_out_reason;

endmodule
